/* hdl/ttf_pkg.sv */
// Shared types, constants and arithmetic helpers of the teleoperation twist filter.
package ttf_pkg;

  localparam int FilterOrder = 2;
  localparam int Channels    = 7;
  localparam int DataW       = 32;
  localparam int CfgW        = 48;
  localparam int CfgIdxW     = 3;
  localparam int PeriodW     = 16;
  localparam int QuoW        = 41;

  typedef enum logic [CfgIdxW-1:0] {
    REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_SCALE, REG_DEAD, REG_LIMIT
  } reg_idx_t;

  localparam logic signed [31:0] ResetB0    = 32'sd259201;
  localparam logic signed [31:0] ResetB1    = 32'sd518295;
  localparam logic signed [31:0] ResetB2    = 32'sd259201;
  localparam logic signed [31:0] ResetA1    = -32'sd2099809511;
  localparam logic signed [31:0] ResetA2    = 32'sd1027034055;
  localparam logic [30:0]        ResetScale = 31'd655360;
  localparam logic [15:0]        ResetDead  = 16'd73;
  localparam logic [47:0]        ResetLimit = 48'd13107200;

  // 2e6 = 15625 * 2^7
  localparam logic [13:0] RateMul = 14'd15625;
  localparam logic signed [63:0] RoundHalf = 64'sh0000_0000_2000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_XMUL, S_XSET, S_RD, S_RDW, S_MAC, S_MACW, S_Y, S_WR,
    S_QMUL, S_QW, S_RATE1, S_RATE2, S_DIV, S_RATE3, S_FMUL, S_FW, S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0] i1;
    logic [1:0] i2;
    logic       neg;
  } qterm_t;

  // Quaternion component order: x, y, z, w. Groups give ang_z, ang_y, ang_x.
  function automatic qterm_t quat_term(input logic [3:0] k);
    qterm_t r;
    case (k)
      4'd0:    r = '{i1: 2'd3, i2: 2'd0, neg: 1'b0};
      4'd1:    r = '{i1: 2'd0, i2: 2'd3, neg: 1'b1};
      4'd2:    r = '{i1: 2'd1, i2: 2'd2, neg: 1'b1};
      4'd3:    r = '{i1: 2'd2, i2: 2'd1, neg: 1'b0};
      4'd4:    r = '{i1: 2'd3, i2: 2'd1, neg: 1'b0};
      4'd5:    r = '{i1: 2'd0, i2: 2'd2, neg: 1'b0};
      4'd6:    r = '{i1: 2'd1, i2: 2'd3, neg: 1'b1};
      4'd7:    r = '{i1: 2'd2, i2: 2'd0, neg: 1'b1};
      4'd8:    r = '{i1: 2'd3, i2: 2'd2, neg: 1'b0};
      4'd9:    r = '{i1: 2'd0, i2: 2'd1, neg: 1'b1};
      4'd10:   r = '{i1: 2'd1, i2: 2'd0, neg: 1'b0};
      4'd11:   r = '{i1: 2'd2, i2: 2'd3, neg: 1'b1};
      default: r = '{i1: 2'd0, i2: 2'd0, neg: 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return 64'sh7fff_ffff_ffff_ffff;
    if (a[63] && b[63] && !s[63]) return 64'sh8000_0000_0000_0000;
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
    if (v == 32'sh8000_0000) return 32'sh7fff_ffff;
    return -v;
  endfunction

endpackage

/* hdl/ttf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ttf_ram #(
  parameter int WIDTH = ttf_pkg::DataW,
  parameter int DEPTH = ttf_pkg::Channels * ttf_pkg::FilterOrder
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ttf_div.sv */
// Restoring divider, one quotient bit per cycle.
module ttf_div #(
  parameter int QW = ttf_pkg::QuoW,
  parameter int DW = ttf_pkg::PeriodW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [QW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int CW = $clog2(QW);

  logic [QW-1:0] dvd;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   r2;
  logic [DW:0]   diff;
  logic          ge;

  assign r2       = {rem, dvd[QW-1]};
  assign diff     = r2 - {1'b0, dsr};
  assign ge       = r2 >= {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[QW-2:0], ge};
      rem <= ge ? diff[DW-1:0] : r2[DW-1:0];
    end
  end

endmodule

/* hdl/teleop_twist_filter.sv */
// Top level of the teleoperation twist filter: sequencer, shared multiplier, history RAMs.
// One item at a time: a new item is taken only while idle, after the previous result
// has been loaded into the output registers, so a finished result that waits for a
// free output holds the next item back. The processing time is set by the single
// 33x33 multiplier stepping through every product and by the bit-serial divider,
// which runs once per angular component.
// Reset restores register defaults and marks all history entries as zero at once.
module teleop_twist_filter #(
  parameter int FILTER_ORDER = ttf_pkg::FilterOrder
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ttf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ttf_pkg::CfgW-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          vel_x,
  input  logic signed [31:0]          vel_y,
  input  logic signed [31:0]          vel_z,
  input  logic signed [31:0]          quat_x,
  input  logic signed [31:0]          quat_y,
  input  logic signed [31:0]          quat_z,
  input  logic signed [31:0]          quat_w,
  input  logic signed [31:0]          force_x,
  input  logic signed [31:0]          force_y,
  input  logic signed [31:0]          force_z,
  input  logic [15:0]                 period_us,
  input  logic                        locked,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          lin_x,
  output logic signed [31:0]          lin_y,
  output logic signed [31:0]          lin_z,
  output logic signed [31:0]          ang_x,
  output logic signed [31:0]          ang_y,
  output logic signed [31:0]          ang_z,
  output logic                        gated
);
  import ttf_pkg::*;

  localparam int Depth = Channels * FILTER_ORDER;
  localparam int AW    = $clog2(Depth);
  localparam int BN    = (FILTER_ORDER < 2) ? 2 : FILTER_ORDER;
  localparam int BW    = $clog2(BN);
  localparam int Taps  = (FILTER_ORDER < 2) ? FILTER_ORDER : 2;
  localparam int NT    = 1 + 2 * Taps;

  function automatic logic signed [31:0] dead(input logic signed [31:0] v,
                                              input logic [15:0] dz);
    logic [32:0] m;
    m = v[31] ? (33'd0 - {1'b1, v}) : {1'b0, v};
    return (m < {17'd0, dz}) ? 32'sd0 : v;
  endfunction

  logic signed [31:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [30:0]        speed_scale;
  logic [15:0]        dead_zone;
  logic [47:0]        force_limit;

  state_t state, state_next;
  logic [2:0]    ch;
  logic [BW-1:0] j, rd_j;
  logic [2:0]    t;
  logic [1:0]    u, g;
  logic [2:0]    fu;

  logic signed [31:0] vin [3];
  logic signed [31:0] qin [4];
  logic signed [31:0] fin [3];
  logic [15:0]        period;
  logic               locked_r;

  logic signed [31:0] xreg, yreg;
  logic signed [31:0] rbuf [BN];
  logic signed [31:0] fbuf [BN];
  logic signed [31:0] q1 [4];
  logic signed [31:0] q2 [4];
  logic signed [31:0] cmd [6];

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] prod, acc, addend;
  logic [63:0]        norm;
  logic               pv, pclr, pneg, pnorm;
  logic               iss_v, iss_clr, iss_neg, iss_norm;

  logic               tneg;
  logic [53:0]        tmag;
  logic signed [63:0] tq, tabs;
  logic [60:0]        rsum;
  logic [44:0]        qm;
  logic signed [63:0] rv;

  logic               ram_we;
  logic [AW-1:0]      base, ram_raddr, ram_waddr;
  logic [31:0]        raw_wdata, filt_wdata, raw_rdata, filt_rdata;
  logic               valid [Depth];
  logic               rd_ok, rd_pend;
  logic signed [31:0] raw_q, filt_q;

  logic               div_start, div_done;
  logic [QuoW-1:0]    div_q;

  logic [2:0]         qi;
  logic [1:0]         fi;
  logic [BW-1:0]      jm1;
  logic signed [31:0] x_scaled, y_new, vsel;
  qterm_t             qt;
  logic               gate;
  logic               out_free;

  assign base      = AW'(ch * FILTER_ORDER);
  assign ram_raddr = base + AW'(j);
  assign ram_waddr = base + AW'(j);
  assign qi        = ch - 3'd3;
  assign fi        = (fu < 3'd3) ? fu[1:0] : 2'(fu - 3'd3);
  assign jm1       = j - BW'(1);
  assign vsel      = (ch < 3'd3) ? vin[ch[1:0]] : 32'sd0;
  assign x_scaled  = sat32(prod >>> 16);
  assign y_new     = sat32(sadd64(acc, RoundHalf) >>> 30);
  assign qt        = quat_term({g, u});
  assign raw_q     = rd_ok ? raw_rdata : 32'sd0;
  assign filt_q    = rd_ok ? filt_rdata : 32'sd0;
  assign mul_full  = mul_a * mul_b;
  assign addend    = pneg ? -prod : prod;
  assign tq        = acc >>> 24;
  assign tabs      = tq[63] ? -tq : tq;
  assign rsum      = 61'({tmag, 7'b0}) + 61'({period, 19'b0});
  assign qm        = (locked_r && g == 2'd0) ? ((45'(div_q) << 3) + (45'(div_q) << 1))
                                             : 45'(div_q);
  assign rv        = (tneg ^ (g != 2'd2)) ? -signed'(64'(qm)) : signed'(64'(qm));
  assign gate      = (norm > {force_limit, 16'b0}) && acc[63];
  assign out_free  = !out_valid || out_ready;

  ttf_ram #(.WIDTH(DataW), .DEPTH(Depth)) u_raw (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(raw_wdata),
    .raddr(ram_raddr), .rdata(raw_rdata)
  );

  ttf_ram #(.WIDTH(DataW), .DEPTH(Depth)) u_filt (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(filt_wdata),
    .raddr(ram_raddr), .rdata(filt_rdata)
  );

  ttf_div #(.QW(QuoW), .DW(PeriodW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(rsum[60:20]),
    .divisor(period), .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0     <= ResetB0;
      coef_b1     <= ResetB1;
      coef_b2     <= ResetB2;
      coef_a1     <= ResetA1;
      coef_a2     <= ResetA2;
      speed_scale <= ResetScale;
      dead_zone   <= ResetDead;
      force_limit <= ResetLimit;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:    coef_b0     <= cfg_data[31:0];
        REG_B1:    coef_b1     <= cfg_data[31:0];
        REG_B2:    coef_b2     <= cfg_data[31:0];
        REG_A1:    coef_a1     <= cfg_data[31:0];
        REG_A2:    coef_a2     <= cfg_data[31:0];
        REG_SCALE: speed_scale <= cfg_data[30:0];
        REG_DEAD:  dead_zone   <= cfg_data[15:0];
        REG_LIMIT: force_limit <= cfg_data[47:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_XMUL;
      S_XMUL:  state_next = S_XSET;
      S_XSET:  state_next = S_RD;
      S_RD:    if (j == BW'(FILTER_ORDER - 1)) state_next = S_RDW;
      S_RDW:   state_next = S_MAC;
      S_MAC:   if (t == 3'(NT - 1)) state_next = S_MACW;
      S_MACW:  state_next = S_Y;
      S_Y:     state_next = S_WR;
      S_WR: begin
        if (j == '0) state_next = (ch == 3'(Channels - 1)) ? S_QMUL : S_XMUL;
      end
      S_QMUL:  if (u == 2'd3) state_next = S_QW;
      S_QW:    state_next = S_RATE1;
      S_RATE1: state_next = S_RATE2;
      S_RATE2: state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_RATE3;
      S_RATE3: state_next = (g == 2'd2) ? S_FMUL : S_QMUL;
      S_FMUL:  if (fu == 3'd5) state_next = S_FW;
      S_FW:    state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    iss_v      = 1'b0;
    iss_clr    = 1'b0;
    iss_neg    = 1'b0;
    iss_norm   = 1'b0;
    ram_we     = 1'b0;
    raw_wdata  = xreg;
    filt_wdata = yreg;
    div_start  = 1'b0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_XMUL: begin
        mul_a = {vsel[31], vsel};
        mul_b = {2'b0, speed_scale};
      end
      S_MAC: begin
        iss_v   = 1'b1;
        iss_clr = (t == 3'd0);
        case (t)
          3'd0: begin
            mul_a = {coef_b0[31], coef_b0};
            mul_b = {xreg[31], xreg};
          end
          3'd1: begin
            mul_a = {coef_b1[31], coef_b1};
            mul_b = {rbuf[BW'(0)][31], rbuf[BW'(0)]};
          end
          3'd2: begin
            mul_a   = {coef_a1[31], coef_a1};
            mul_b   = {fbuf[BW'(0)][31], fbuf[BW'(0)]};
            iss_neg = 1'b1;
          end
          3'd3: begin
            mul_a = {coef_b2[31], coef_b2};
            mul_b = {rbuf[BW'(1)][31], rbuf[BW'(1)]};
          end
          default: begin
            mul_a   = {coef_a2[31], coef_a2};
            mul_b   = {fbuf[BW'(1)][31], fbuf[BW'(1)]};
            iss_neg = 1'b1;
          end
        endcase
      end
      S_WR: begin
        ram_we = 1'b1;
        if (j != '0) begin
          raw_wdata  = rbuf[jm1];
          filt_wdata = fbuf[jm1];
        end
      end
      S_QMUL: begin
        iss_v   = 1'b1;
        iss_clr = (u == 2'd0);
        iss_neg = qt.neg;
        mul_a   = {q1[qt.i1][31], q1[qt.i1]};
        mul_b   = {q2[qt.i2][31], q2[qt.i2]};
      end
      S_RATE2: div_start = 1'b1;
      S_FMUL: begin
        iss_v    = 1'b1;
        iss_norm = (fu < 3'd3);
        iss_clr  = (fu == 3'd0) || (fu == 3'd3);
        mul_a    = {fin[fi][31], fin[fi]};
        mul_b    = (fu < 3'd3) ? {fin[fi][31], fin[fi]} : {cmd[fi][31], cmd[fi]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= '0;
      j         <= '0;
      t         <= '0;
      u         <= '0;
      g         <= '0;
      fu        <= '0;
      pv        <= 1'b0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < Depth; i++) valid[i] <= 1'b0;
    end else begin
      state   <= state_next;
      pv      <= iss_v;
      rd_pend <= (state == S_RD);
      if (ram_we) valid[ram_waddr] <= 1'b1;
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_valid) ch <= '0;
        S_XSET: j <= '0;
        S_RD:   if (j != BW'(FILTER_ORDER - 1)) j <= j + BW'(1);
        S_RDW:  t <= '0;
        S_MAC:  t <= t + 3'd1;
        S_Y:    j <= BW'(FILTER_ORDER - 1);
        S_WR: begin
          if (j != '0) begin
            j <= j - BW'(1);
          end else if (ch != 3'(Channels - 1)) begin
            ch <= ch + 3'd1;
          end else begin
            u <= '0;
            g <= '0;
          end
        end
        S_QMUL: u <= u + 2'd1;
        S_RATE3: begin
          u  <= '0;
          g  <= g + 2'd1;
          fu <= '0;
        end
        S_FMUL: fu <= fu + 3'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_ok <= valid[ram_raddr];
    prod  <= mul_full[63:0];
    pclr  <= iss_clr;
    pneg  <= iss_neg;
    pnorm <= iss_norm;
    if (pv) begin
      if (pnorm) norm <= (pclr ? 64'd0 : norm) + prod;
      else acc <= sadd64(pclr ? 64'sd0 : acc, addend);
    end
    if (rd_pend) begin
      rbuf[rd_j] <= raw_q;
      fbuf[rd_j] <= filt_q;
    end
    rd_j <= j;
    case (state)
      S_IDLE: begin
        vin[0]   <= vel_x;
        vin[1]   <= vel_y;
        vin[2]   <= vel_z;
        qin[0]   <= quat_x;
        qin[1]   <= quat_y;
        qin[2]   <= quat_z;
        qin[3]   <= quat_w;
        fin[0]   <= force_x;
        fin[1]   <= force_y;
        fin[2]   <= force_z;
        period   <= (period_us == 16'd0) ? 16'd1 : period_us;
        locked_r <= locked;
      end
      S_XSET: xreg <= (ch < 3'd3) ? x_scaled : qin[qi[1:0]];
      S_Y: begin
        yreg <= y_new;
        if (ch < 3'd3) begin
          cmd[ch] <= (ch < 3'd2) ? neg32(y_new) : y_new;
        end else begin
          q2[qi[1:0]] <= y_new;
          q1[qi[1:0]] <= fbuf[BW'(0)];
        end
      end
      S_RATE1: begin
        tneg <= tq[63];
        tmag <= tabs[39:0] * RateMul;
      end
      S_RATE3: cmd[3'd5 - {1'b0, g}] <= sat32(rv);
      S_FIN: begin
        if (out_free) begin
          lin_x <= gate ? 32'sd0 : dead(cmd[0], dead_zone);
          lin_y <= gate ? 32'sd0 : dead(cmd[1], dead_zone);
          lin_z <= gate ? 32'sd0 : dead(cmd[2], dead_zone);
          ang_x <= gate ? 32'sd0 : dead(cmd[3], dead_zone);
          ang_y <= gate ? 32'sd0 : dead(cmd[4], dead_zone);
          ang_z <= gate ? 32'sd0 : dead(cmd[5], dead_zone);
          gated <= gate;
        end
      end
      default: ;
    endcase
  end

endmodule
